>>> design/assert_macros.svh
// assertion helpers for the wait-queue manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every rising clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

>>> design/swqm_pkg.sv
package swqm_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int NUM_PROCS = 32;
    localparam int PID_W = 5;
    localparam int ADDR_W = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_OUT    = 2'd2,
        ACT_HEAD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NULL      = 3'd3,
        ST_BLOCKED   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RDQ,
        S_UNLINK,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request
        logic scan_start;  // clear scan counter and results
        logic scan_step;   // look at one descriptor
        logic do_insert;   // append or allocate
        logic rd_queue;    // fetch head and tail of target descriptor
        logic do_unlink;   // unlink target process
        logic set_result;  // mark result valid with result process
        logic [2:0] status;
        logic out_load;    // present result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic addr_null;
        logic pid_blocked;
        logic scan_done;
        logic found;
        logic free_found;
    } stat_t;

endpackage

>>> design/swqm_ctrl.sv
module swqm_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_busy,
    output logic            idle,
    input  swqm_pkg::stat_t st,
    output swqm_pkg::cmd_t  cmd
);

    swqm_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swqm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swqm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = swqm_pkg::S_SCAN;
                end
            end
            swqm_pkg::S_SCAN:
            begin
                if (st.action == swqm_pkg::ACT_OUT)
                begin
                    state_next = st.pid_blocked ? swqm_pkg::S_RDQ : swqm_pkg::S_DONE;
                end
                else if (st.addr_null ||
                         (st.action == swqm_pkg::ACT_INSERT && st.pid_blocked))
                begin
                    state_next = swqm_pkg::S_DONE;
                end
                else if (st.scan_done)
                begin
                    state_next = swqm_pkg::S_DECIDE;
                end
            end
            swqm_pkg::S_DECIDE:
            begin
                if (st.action == swqm_pkg::ACT_REMOVE && st.found)
                begin
                    state_next = swqm_pkg::S_RDQ;
                end
                else
                begin
                    state_next = swqm_pkg::S_DONE;
                end
            end
            swqm_pkg::S_RDQ:    state_next = swqm_pkg::S_UNLINK;
            swqm_pkg::S_UNLINK: state_next = swqm_pkg::S_DONE;
            swqm_pkg::S_DONE:
            begin
                if (!out_busy)
                begin
                    state_next = swqm_pkg::S_IDLE;
                end
            end
            default:            state_next = swqm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.status = swqm_pkg::ST_OK;
        idle = 1'b0;
        unique case (state_reg)
            swqm_pkg::S_IDLE:
            begin
                idle = 1'b1;
                cmd.load = in_fire;
                cmd.scan_start = in_fire;
            end
            swqm_pkg::S_SCAN:
            begin
                if (st.action == swqm_pkg::ACT_OUT)
                begin
                    if (st.pid_blocked)
                    begin
                        cmd.set_result = 1'b1;
                    end
                    else
                    begin
                        cmd.status = swqm_pkg::ST_NOT_FOUND;
                    end
                end
                else if (st.addr_null)
                begin
                    cmd.status = swqm_pkg::ST_NULL;
                end
                else if (st.action == swqm_pkg::ACT_INSERT && st.pid_blocked)
                begin
                    cmd.status = swqm_pkg::ST_BLOCKED;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            swqm_pkg::S_DECIDE:
            begin
                if (st.action == swqm_pkg::ACT_INSERT)
                begin
                    if (st.found || st.free_found)
                    begin
                        cmd.do_insert = 1'b1;
                    end
                    else
                    begin
                        cmd.status = swqm_pkg::ST_NO_FREE;
                    end
                end
                else if (!st.found)
                begin
                    cmd.status = swqm_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    cmd.set_result = 1'b1;
                end
            end
            swqm_pkg::S_RDQ:    cmd.rd_queue = 1'b1;
            swqm_pkg::S_UNLINK: cmd.do_unlink = 1'b1;
            swqm_pkg::S_DONE:   cmd.out_load = !out_busy;
            default:            cmd = '0;
        endcase
    end

endmodule

>>> design/swqm_datapath.sv
module swqm_datapath
#(
    parameter int NUM_SLOTS = swqm_pkg::NUM_SLOTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                action,
    input  logic [swqm_pkg::ADDR_W-1:0] sem_address,
    input  logic [swqm_pkg::PID_W-1:0]  process_id,
    input  swqm_pkg::cmd_t            cmd,
    output swqm_pkg::stat_t           st,
    output logic [2:0]                res_status,
    output logic [swqm_pkg::PID_W-1:0]  res_process,
    output logic                      res_valid
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = swqm_pkg::PID_W;

    // descriptor table and process links
    logic [swqm_pkg::ADDR_W-1:0] desc_address_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]        desc_active_reg;
    logic [PW-1:0]               queue_head_reg [NUM_SLOTS];
    logic [PW-1:0]               queue_tail_reg [NUM_SLOTS];
    logic [PW-1:0]               next_reg [swqm_pkg::NUM_PROCS];
    logic [PW-1:0]               prev_reg [swqm_pkg::NUM_PROCS];
    logic [SW-1:0]               pdesc_reg [swqm_pkg::NUM_PROCS];
    logic [swqm_pkg::NUM_PROCS-1:0] blocked_reg;

    // request and working registers
    logic [1:0]                  act_reg;
    logic [swqm_pkg::ADDR_W-1:0] addr_reg;
    logic [PW-1:0]               pid_reg;
    logic [SW:0]                 idx_reg;
    logic                        found_reg, free_reg;
    logic [SW-1:0]               hit_reg, free_idx_reg;
    logic [SW-1:0]               tgt_reg;
    logic [PW-1:0]               upid_reg;
    logic [PW-1:0]               qh_reg, qt_reg;
    logic [2:0]                  rstat_reg;
    logic [PW-1:0]               rproc_reg;
    logic                        rvalid_reg;

    logic [SW-1:0] idx;
    logic [SW-1:0] ins_d;
    logic [SW-1:0] pd;

    assign idx = idx_reg[SW-1:0];
    assign ins_d = found_reg ? hit_reg : free_idx_reg;
    assign pd = pdesc_reg[upid_reg];

    assign st.action = act_reg;
    assign st.addr_null = (addr_reg == '0);
    assign st.pid_blocked = blocked_reg[pid_reg];
    assign st.scan_done = (idx_reg == (SW+1)'(NUM_SLOTS - 1));
    assign st.found = found_reg;
    assign st.free_found = free_reg;

    assign res_status = rstat_reg;
    assign res_process = rproc_reg;
    assign res_valid = rvalid_reg;

    // request capture, scan over the descriptors, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            addr_reg <= '0;
            pid_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            hit_reg <= '0;
            free_idx_reg <= '0;
            tgt_reg <= '0;
            upid_reg <= '0;
            qh_reg <= '0;
            qt_reg <= '0;
            rstat_reg <= '0;
            rproc_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg <= action;
                addr_reg <= sem_address;
                pid_reg <= process_id;
                upid_reg <= process_id;
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                free_reg <= 1'b0;
                rstat_reg <= swqm_pkg::ST_OK;
                rproc_reg <= '0;
                rvalid_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (desc_active_reg[idx] && desc_address_reg[idx] == addr_reg && !found_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg <= idx;
                end
                if (!desc_active_reg[idx] && !free_reg)
                begin
                    free_reg <= 1'b1;
                    free_idx_reg <= idx;
                end
            end
            if (cmd.set_result)
            begin
                rvalid_reg <= 1'b1;
                if (act_reg == swqm_pkg::ACT_OUT)
                begin
                    rproc_reg <= pid_reg;
                end
                else
                begin
                    rproc_reg <= queue_head_reg[hit_reg];
                    upid_reg <= queue_head_reg[hit_reg];
                end
            end
            if (cmd.status != swqm_pkg::ST_OK)
            begin
                rstat_reg <= cmd.status;
            end
            if (cmd.rd_queue)
            begin
                tgt_reg <= pd;
                qh_reg <= queue_head_reg[pd];
                qt_reg <= queue_tail_reg[pd];
            end
        end
    end

    // table updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_active_reg <= '0;
            blocked_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                desc_address_reg[i] <= '0;
                queue_head_reg[i] <= '0;
                queue_tail_reg[i] <= '0;
            end
            for (int i = 0; i < swqm_pkg::NUM_PROCS; i++)
            begin
                next_reg[i] <= '0;
                prev_reg[i] <= '0;
                pdesc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.do_insert)
            begin
                if (found_reg)
                begin
                    next_reg[queue_tail_reg[hit_reg]] <= pid_reg;
                    prev_reg[pid_reg] <= queue_tail_reg[hit_reg];
                    queue_tail_reg[hit_reg] <= pid_reg;
                end
                else
                begin
                    desc_active_reg[free_idx_reg] <= 1'b1;
                    desc_address_reg[free_idx_reg] <= addr_reg;
                    queue_head_reg[free_idx_reg] <= pid_reg;
                    queue_tail_reg[free_idx_reg] <= pid_reg;
                end
                pdesc_reg[pid_reg] <= ins_d;
                blocked_reg[pid_reg] <= 1'b1;
            end
            if (cmd.do_unlink)
            begin
                priority if (qh_reg == upid_reg && qt_reg == upid_reg)
                begin
                    desc_active_reg[tgt_reg] <= 1'b0;
                end
                else if (qh_reg == upid_reg)
                begin
                    queue_head_reg[tgt_reg] <= next_reg[upid_reg];
                end
                else if (qt_reg == upid_reg)
                begin
                    queue_tail_reg[tgt_reg] <= prev_reg[upid_reg];
                end
                else
                begin
                    next_reg[prev_reg[upid_reg]] <= next_reg[upid_reg];
                    prev_reg[next_reg[upid_reg]] <= prev_reg[upid_reg];
                end
                blocked_reg[upid_reg] <= 1'b0;
            end
        end
    end

endmodule

>>> design/semaphore_wait_queue_manager_top.sv
// Semaphore wait-queue manager.
// Request channel s_axis: one transaction per request (action, address,
// process id). Result channel m_axis: one transaction per request carrying
// status, result process and result valid flag.
// One request is worked at a time. Insert, peek and remove requests scan
// the pool: a scan visits one descriptor per cycle to find the address and
// the lowest free slot, then a decide state acts on the result and a done
// state loads the result. A remove that pops a process adds a queue read
// state and an unlink state for the link update. Out requests skip the
// scan and take the same queue read and unlink states when the process is
// blocked; null addresses and double blocking also answer without a scan.
// s_axis_tready returns in the cycle after the result is loaded.
// The result sits in an output register; the next request is accepted
// once the result is loaded, even while the receiver stalls the
// previous one, but a second result waits until the register frees.
// Reset clears the whole descriptor pool and all process links at once;
// the block is ready as soon as reset is released.
`include "assert_macros.svh"
module semaphore_wait_queue_manager_top
#(
    parameter int NUM_SLOTS = swqm_pkg::NUM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action[1:0], sem_address[33:2], process_id[38:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[2:0], result_process[7:3], result_valid[8]
);

    swqm_pkg::cmd_t  cmd;
    swqm_pkg::stat_t st;
    logic            idle;
    logic            in_fire;
    logic [2:0]      res_status;
    logic [4:0]      res_process;
    logic            res_valid;
    logic            out_valid_reg;
    logic [8:0]      out_data_reg;

    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    swqm_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_fire(in_fire),
        .out_busy(out_valid_reg && !m_axis_tready),
        .idle(idle),
        .st(st),
        .cmd(cmd)
    );

    swqm_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .action(s_axis_tdata[1:0]),
        .sem_address(s_axis_tdata[33:2]),
        .process_id(s_axis_tdata[38:34]),
        .cmd(cmd),
        .st(st),
        .res_status(res_status),
        .res_process(res_process),
        .res_valid(res_valid)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= {res_valid, res_process, res_status};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'b0, out_data_reg};

    `ASSERT_CLK(a_no_load_when_stalled, clk, rst_n,
        !(cmd.out_load && out_valid_reg && !m_axis_tready), "result overwritten")
    `ASSERT_CLK(a_accept_starts_scan, clk, rst_n,
        in_fire |=> !s_axis_tready, "accepted while busy")
    `ASSERT_CLK(a_valid_has_ok, clk, rst_n,
        !(m_axis_tvalid && m_axis_tdata[8] && m_axis_tdata[2:0] != swqm_pkg::ST_OK),
        "valid result with error status")

endmodule

>>> tb/sv/semaphore_wait_queue_manager_top_test.sv
module semaphore_wait_queue_manager_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = swqm_pkg::NUM_SLOTS_DEF;
    localparam int PROCS = swqm_pkg::NUM_PROCS;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic proc_valid;
        logic [4:0] proc_id;
        swqm_pkg::status_t status;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;

    // shadow of the wait-queue state
    logic [31:0] sh_addr [SLOTS];
    logic sh_active [SLOTS];
    logic [4:0] sh_head [SLOTS];
    logic [4:0] sh_tail [SLOTS];
    logic [4:0] sh_next [PROCS];
    logic [4:0] sh_prev [PROCS];
    logic [4:0] sh_desc [PROCS];
    logic sh_blocked [PROCS];

    verdict_t pending_verdicts[$];
    int mismatches;
    int verdicts_seen;
    int idle_cycles;
    logic timed_out;
    logic rx_stall_enable;
    int n_sent;

    semaphore_wait_queue_manager_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int find_slot(logic [31:0] addr);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sh_active[i] && sh_addr[i] == addr)
                return i;
        end
        return SLOTS;
    endfunction

    function automatic void detach_proc(logic [4:0] p);
        int d;
        d = sh_desc[p];
        if (sh_head[d] == p && sh_tail[d] == p)
            sh_active[d] = 1'b0;
        else if (sh_head[d] == p)
            sh_head[d] = sh_next[p];
        else if (sh_tail[d] == p)
            sh_tail[d] = sh_prev[p];
        else
        begin
            sh_next[sh_prev[p]] = sh_next[p];
            sh_prev[sh_next[p]] = sh_prev[p];
        end
        sh_blocked[p] = 1'b0;
    endfunction

    // expected outcome of one request, updating the shadow state
    function automatic verdict_t queue_outcome(swqm_pkg::action_t act, logic [31:0] addr,
                                               logic [4:0] pid);
        verdict_t v;
        int d;
        v = '{proc_valid: 1'b0, proc_id: 5'd0, status: swqm_pkg::ST_OK};
        if (act == swqm_pkg::ACT_INSERT)
        begin
            if (addr == 32'd0)
                v.status = swqm_pkg::ST_NULL;
            else if (sh_blocked[pid])
                v.status = swqm_pkg::ST_BLOCKED;
            else
            begin
                d = find_slot(addr);
                if (d < SLOTS)
                begin
                    sh_next[sh_tail[d]] = pid;
                    sh_prev[pid] = sh_tail[d];
                    sh_tail[d] = pid;
                end
                else
                begin
                    d = 0;
                    while (d < SLOTS && sh_active[d])
                        d++;
                    if (d >= SLOTS)
                        v.status = swqm_pkg::ST_NO_FREE;
                    else
                    begin
                        sh_active[d] = 1'b1;
                        sh_addr[d] = addr;
                        sh_head[d] = pid;
                        sh_tail[d] = pid;
                    end
                end
                if (v.status == swqm_pkg::ST_OK)
                begin
                    sh_desc[pid] = d[4:0];
                    sh_blocked[pid] = 1'b1;
                end
            end
        end
        else if (act == swqm_pkg::ACT_OUT)
        begin
            if (!sh_blocked[pid])
                v.status = swqm_pkg::ST_NOT_FOUND;
            else
            begin
                detach_proc(pid);
                v.proc_id = pid;
                v.proc_valid = 1'b1;
            end
        end
        else
        begin
            if (addr == 32'd0)
                v.status = swqm_pkg::ST_NULL;
            else
            begin
                d = find_slot(addr);
                if (d >= SLOTS)
                    v.status = swqm_pkg::ST_NOT_FOUND;
                else
                begin
                    v.proc_id = sh_head[d];
                    v.proc_valid = 1'b1;
                    if (act == swqm_pkg::ACT_REMOVE)
                        detach_proc(v.proc_id);
                end
            end
        end
        return v;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one request and record its expected result
    task automatic send_request(swqm_pkg::action_t act, logic [31:0] addr, logic [4:0] pid);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tdata <= {1'b0, pid, addr, act};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_verdicts.push_back(queue_outcome(act, addr, pid));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0 && !timed_out)
            @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rx_stall_enable)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    // result checker
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[8:0];
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got !== want || m_axis_tdata[15:9] !== 7'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d proc %0d valid %0d, got %0d %0d %0d",
                                 want.status, want.proc_id, want.proc_valid,
                                 m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tdata[8]);
                end
            end
        end
    end

    // watchdog on idle cycles
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_verdicts.size() == 0 && !s_axis_tvalid))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                timed_out <= 1'b1;
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom();
        if (r == 1)
            return 32'd0;
        return $urandom_range(1, 6) << ($urandom_range(0, 1) * 26);
    endfunction

    task automatic test_directed();
        send_request(swqm_pkg::ACT_HEAD, 32'hFFFF_FFFF, 5'd0);
        send_request(swqm_pkg::ACT_REMOVE, 32'd5, 5'd0);
        send_request(swqm_pkg::ACT_OUT, 32'd0, 5'd31);
        send_request(swqm_pkg::ACT_INSERT, 32'd0, 5'd1);
        send_request(swqm_pkg::ACT_HEAD, 32'd0, 5'd0);
        send_request(swqm_pkg::ACT_REMOVE, 32'd0, 5'd0);
        send_request(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd31);
        send_request(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd0);
        send_request(swqm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 5'd10);
        send_request(swqm_pkg::ACT_INSERT, 32'h0000_0001, 5'd31);
        send_request(swqm_pkg::ACT_HEAD, 32'hFFFF_FFFF, 5'd3);
        // unlink middle, then tail, then the last remaining process
        send_request(swqm_pkg::ACT_OUT, 32'hAAAA_5555, 5'd0);
        send_request(swqm_pkg::ACT_OUT, 32'd1, 5'd10);
        send_request(swqm_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 5'd7);
        send_request(swqm_pkg::ACT_HEAD, 32'hFFFF_FFFF, 5'd0);
        send_request(swqm_pkg::ACT_OUT, 32'd0, 5'd10);
    endtask

    // fill every descriptor, free one and refill it, try a double block, then empty the pool
    task automatic test_pool_exhaustion();
        for (int i = 0; i < 32; i++)
            send_request(swqm_pkg::ACT_INSERT, 32'h8000_0000 | i, i[4:0]);
        drain_results();
        send_request(swqm_pkg::ACT_OUT, 32'd0, 5'd4);
        send_request(swqm_pkg::ACT_INSERT, 32'h1234_5678, 5'd4);
        send_request(swqm_pkg::ACT_INSERT, 32'h8000_0007, 5'd4);
        for (int i = 0; i < 32; i++)
            send_request(i[0] ? swqm_pkg::ACT_REMOVE : swqm_pkg::ACT_OUT,
                         32'h8000_0000 | i, i[4:0]);
    endtask

    task automatic test_random_mix(int count);
        int r;
        swqm_pkg::action_t act;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            act = r < 40 ? swqm_pkg::ACT_INSERT : r < 60 ? swqm_pkg::ACT_REMOVE :
                  r < 80 ? swqm_pkg::ACT_OUT : swqm_pkg::ACT_HEAD;
            send_request(act, rand_addr(), 5'($urandom_range(0, 31)));
            if (i == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        rx_stall_enable = 1'b0;
        timed_out = 1'b0;
        mismatches = 0;
        verdicts_seen = 0;
        idle_cycles = 0;
        n_sent = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_addr[i] = '0; sh_active[i] = 0; sh_head[i] = '0; sh_tail[i] = '0;
        end
        for (int i = 0; i < PROCS; i++)
        begin
            sh_next[i] = '0; sh_prev[i] = '0; sh_desc[i] = '0; sh_blocked[i] = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        rx_stall_enable <= 1'b1;
        test_pool_exhaustion();
        test_random_mix(600);
        rx_stall_enable <= 1'b0;
        test_random_mix(200);
        rx_stall_enable <= 1'b1;
        test_random_mix(340);
        drain_results();
        repeat (100) @(negedge clk);
        $display("sent %0d requests, checked %0d results, %0d mismatches",
                 n_sent, verdicts_seen, mismatches);
        $display("covered null keys, pool exhaustion, double blocking and queue unlinks");
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
